// ===== hw/rtl/kspi_pkg.sv =====
// ----------------------------------------------------------------------------
// kspi_pkg
// shared constants and types of the keyframe spline path interpolator
// ----------------------------------------------------------------------------
package kspi_pkg;

   localparam int MAX_KEYS   = 64;
   localparam int KEY_AW     = $clog2(MAX_KEYS);
   localparam int COORD_BITS = 16;
   localparam int TIME_BITS  = 24;
   localparam int LEN_BITS   = 7;
   localparam int DELTA_BITS = 16;
   localparam int FRAC_BITS  = 16;
   // entry layout: pos x,y,z, look x,y,z, then time on top
   localparam int ENTRY_W    = 6 * COORD_BITS + TIME_BITS;

   // request operations
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_TICK  = 1'b1;

   typedef logic [ENTRY_W-1:0] entry_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOOK,
      ST_DEC,
      ST_FETCH,
      ST_FRAC,
      ST_DIV,
      ST_SQ,
      ST_CUBE,
      ST_WGT,
      ST_MAC,
      ST_DONE
   } state_type;

endpackage

// ===== hw/rtl/keyframe_spline_path_interpolator_core.sv =====
// ----------------------------------------------------------------------------
// keyframe_spline_path_interpolator_core
// catmull-rom camera path: keyframe table, segment tracking, cubic blend
// ----------------------------------------------------------------------------
// sequence: a write is stored when it is taken; a tick runs the advance test, four key
// reads, the fraction, a 16-bit divide, three weight steps, 24 serial multiply-accumulates
// and the output load; the divide is skipped when the fraction clamps, a tick that passes
// the last key goes from the advance test to the output load, one beyond the path at once
// throughput: one item at a time, set by the single read port and multiplier
// reset: synchronous, clears elapsed time, segment, held point; path_length 2
// the keyframe table is not cleared by reset
// ----------------------------------------------------------------------------
module keyframe_spline_path_interpolator_core (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_op,
   input  logic [5:0]         req_key_index,
   input  logic signed [15:0] req_key_pos_x,
   input  logic signed [15:0] req_key_pos_y,
   input  logic signed [15:0] req_key_pos_z,
   input  logic signed [15:0] req_key_look_x,
   input  logic signed [15:0] req_key_look_y,
   input  logic signed [15:0] req_key_look_z,
   input  logic [23:0]        req_key_time,
   input  logic [15:0]        req_delta_t,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_cam_pos_x,
   output logic signed [15:0] rsp_cam_pos_y,
   output logic signed [15:0] rsp_cam_pos_z,
   output logic signed [15:0] rsp_cam_look_x,
   output logic signed [15:0] rsp_cam_look_y,
   output logic signed [15:0] rsp_cam_look_z,
   output logic [6:0]         rsp_segment,
   output logic               rsp_finished,
   // path length register
   input  logic               csr_wr_en,
   input  logic [6:0]         csr_wr_data
);

   localparam int CB = kspi_pkg::COORD_BITS;
   localparam int TB = kspi_pkg::TIME_BITS;
   localparam int LB = kspi_pkg::LEN_BITS;
   localparam int AW = kspi_pkg::KEY_AW;
   localparam int WB = 20;            // weight width, signed
   localparam int PB = WB + CB;       // product width
   localparam int AB = PB + 2;        // accumulator width
   localparam int FB = 54;            // exact weight polynomial width
   localparam int UB = kspi_pkg::FRAC_BITS + 1;
   localparam int TOP = 6 * CB;       // time field offset in an entry

   kspi_pkg::state_type state_ff, state_in;

   logic [TB-1:0]      elapsed_ff, elapsed_in;
   logic [LB-1:0]      seg_ff, seg_in;
   logic [LB-1:0]      len_ff, len_in;      // raw register
   logic [LB-1:0]      n_ff, n_in;          // clamped length of this tick
   logic               fin_ff, fin_in;
   logic [CB-1:0]      held_ff [6];
   logic [CB-1:0]      held_in [6];
   kspi_pkg::entry_type pts_ff [4];
   kspi_pkg::entry_type pts_in [4];
   logic [2:0]         fcnt_ff, fcnt_in;
   logic [UB-1:0]      u_ff, u_in;
   logic [2*UB-1:0]    u2_ff, u2_in;
   logic [3*UB-1:0]    u3_ff, u3_in;
   logic signed [WB-1:0] w_ff [4];
   logic signed [WB-1:0] w_in [4];
   logic [4:0]         mcnt_ff, mcnt_in;
   logic [4:0]         mcd_ff, mcd_in;
   logic               mv_ff, mv_in;
   logic signed [PB-1:0] prod_ff, prod_in;
   logic signed [AB-1:0] acc_ff, acc_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [CB-1:0]      rsp_co_ff [6];
   logic [CB-1:0]      rsp_co_in [6];
   logic [LB-1:0]      rsp_seg_ff, rsp_seg_in;
   logic               rsp_fin_ff, rsp_fin_in;

   // table ports
   logic                mem_we;
   kspi_pkg::entry_type mem_wdata, mem_rdata;
   logic [AW-1:0]       mem_raddr;

   // divider
   logic               div_start, div_done;
   logic [TB-1:0]      div_num, div_den;
   logic [kspi_pkg::FRAC_BITS-1:0] div_q;

   // scratch
   logic               req_xfer;
   logic [TB:0]        esum;
   logic [LB:0]        seg2;
   logic [LB-1:0]      seg_nxt;
   logic [TB-1:0]      t0, t1, rd_time;
   logic signed [FB-1:0] a1, a2, a3;
   logic signed [FB-1:0] f [4];
   logic signed [FB-1:0] fr;
   logic signed [CB-1:0] coord;
   logic signed [AB-1:0] sum, rsum;
   logic signed [AB-18:0] rq;
   logic [LB-1:0]      n_cl;

   kspi_key_mem u_mem (
      .clock  (clock),
      .wr_en  (mem_we),
      .wr_addr(req_key_index),
      .wr_data(mem_wdata),
      .rd_addr(mem_raddr),
      .rd_data(mem_rdata)
   );

   kspi_div u_div (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .num  (div_num),
      .den  (div_den),
      .done (div_done),
      .quot (div_q)
   );

   assign req_stall = (state_ff != kspi_pkg::ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign mem_we    = req_xfer && (req_op == kspi_pkg::OP_WRITE);
   assign mem_wdata = {req_key_time, req_key_look_z, req_key_look_y, req_key_look_x,
                       req_key_pos_z, req_key_pos_y, req_key_pos_x};

   // clamp the length register to 2..MAX_KEYS
   always_comb begin
      if (len_ff < LB'(2)) begin
         n_cl = LB'(2);
      end else if (len_ff > LB'(kspi_pkg::MAX_KEYS)) begin
         n_cl = LB'(kspi_pkg::MAX_KEYS);
      end else begin
         n_cl = len_ff;
      end
   end

   // exact cubic weights, 48 fraction bits, then rounded half up to 16
   always_comb begin
      a3 = $signed({3'b0, u3_ff});
      a2 = $signed({{(FB - 2*UB - 16){1'b0}}, u2_ff, 16'b0});
      a1 = $signed({{(FB - UB - 32){1'b0}}, u_ff, 32'b0});
      f[0] = -a3 + (a2 <<< 1) - a1;
      f[1] = (a3 <<< 1) + a3 - (a2 <<< 2) - a2 + (FB'(1) <<< 49);
      f[2] = -(a3 <<< 1) - a3 + (a2 <<< 2) + a1;
      f[3] = a3 - a2;
   end

   always_comb begin
      seg2         = {1'b0, seg_ff} + (LB + 1)'(2);
      seg_nxt      = seg_ff + 1'b1;
      t0           = pts_ff[1][TOP +: TB];
      t1           = pts_ff[2][TOP +: TB];
      rd_time      = mem_rdata[TOP +: TB];
      state_in     = state_ff;
      elapsed_in   = elapsed_ff;
      seg_in       = seg_ff;
      len_in       = len_ff;
      n_in         = n_ff;
      fin_in       = fin_ff;
      held_in      = held_ff;
      pts_in       = pts_ff;
      fcnt_in      = fcnt_ff;
      u_in         = u_ff;
      u2_in        = u2_ff;
      u3_in        = u3_ff;
      w_in         = w_ff;
      mcnt_in      = mcnt_ff;
      mcd_in       = mcnt_ff;
      mv_in        = 1'b0;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_co_in    = rsp_co_ff;
      rsp_seg_in   = rsp_seg_ff;
      rsp_fin_in   = rsp_fin_ff;
      mem_raddr    = seg_nxt[AW-1:0];
      div_start    = 1'b0;
      div_num      = elapsed_ff - t0;
      div_den      = t1 - t0;
      esum         = {1'b0, elapsed_ff} + {{(TB - kspi_pkg::DELTA_BITS + 1){1'b0}}, req_delta_t};
      coord        = $signed(pts_ff[mcnt_ff[1:0]][mcnt_ff[4:2] * CB +: CB]);
      sum          = '0;
      rsum         = '0;
      rq           = '0;
      fr           = '0;

      if (csr_wr_en) begin
         len_in = csr_wr_data;
      end

      // a taken response frees the output register
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         kspi_pkg::ST_IDLE: begin
            if (req_xfer && (req_op == kspi_pkg::OP_TICK)) begin
               // saturating elapsed time
               elapsed_in = esum[TB] ? '1 : esum[TB-1:0];
               n_in = n_cl;
               if (seg2 > {1'b0, n_cl}) begin
                  // beyond the path: repeat the held point
                  fin_in   = 1'b1;
                  state_in = kspi_pkg::ST_DONE;
               end else begin
                  state_in = kspi_pkg::ST_LOOK;
               end
            end
         end

         kspi_pkg::ST_LOOK: begin
            // read the next key for the advance test
            mem_raddr = seg_nxt[AW-1:0];
            state_in  = kspi_pkg::ST_DEC;
         end

         kspi_pkg::ST_DEC: begin
            fcnt_in = '0;
            fin_in  = 1'b0;
            state_in = kspi_pkg::ST_FETCH;
            if (elapsed_ff > rd_time) begin
               seg_in = seg_nxt;
               if (seg2 == {1'b0, n_ff}) begin
                  // last key passed: hold the end point
                  for (int c = 0; c < 6; c++) begin
                     held_in[c] = mem_rdata[c*CB +: CB];
                  end
                  fin_in   = 1'b1;
                  state_in = kspi_pkg::ST_DONE;
               end
            end
         end

         kspi_pkg::ST_FETCH: begin
            // neighbor order: before, cur, next, after
            case (fcnt_ff[1:0])
               2'd0: mem_raddr = (seg_ff == '0) ? seg_ff[AW-1:0] : AW'(seg_ff - 1'b1);
               2'd1: mem_raddr = seg_ff[AW-1:0];
               2'd2: mem_raddr = seg_nxt[AW-1:0];
               default: mem_raddr = (seg2 == {1'b0, n_ff}) ? seg_nxt[AW-1:0]
                                                         : AW'(seg2);
            endcase
            if (fcnt_ff != 3'd0) begin
               pts_in[2'(fcnt_ff - 3'd1)] = mem_rdata;
            end
            fcnt_in = fcnt_ff + 1'b1;
            if (fcnt_ff == 3'd4) begin
               state_in = kspi_pkg::ST_FRAC;
            end
         end

         kspi_pkg::ST_FRAC: begin
            state_in = kspi_pkg::ST_SQ;
            if (t1 <= t0) begin
               u_in = UB'(1) << kspi_pkg::FRAC_BITS;
            end else if (elapsed_ff <= t0) begin
               u_in = '0;
            end else if ((elapsed_ff - t0) >= (t1 - t0)) begin
               u_in = UB'(1) << kspi_pkg::FRAC_BITS;
            end else begin
               div_start = 1'b1;
               state_in  = kspi_pkg::ST_DIV;
            end
         end

         kspi_pkg::ST_DIV: begin
            if (div_done) begin
               u_in     = {1'b0, div_q};
               state_in = kspi_pkg::ST_SQ;
            end
         end

         kspi_pkg::ST_SQ: begin
            u2_in    = u_ff * u_ff;
            state_in = kspi_pkg::ST_CUBE;
         end

         kspi_pkg::ST_CUBE: begin
            u3_in    = u2_ff * u_ff;
            state_in = kspi_pkg::ST_WGT;
         end

         kspi_pkg::ST_WGT: begin
            for (int j = 0; j < 4; j++) begin
               fr      = f[j] + (FB'(1) <<< 31);
               w_in[j] = fr[32 +: WB];
            end
            mcnt_in  = '0;
            state_in = kspi_pkg::ST_MAC;
         end

         kspi_pkg::ST_MAC: begin
            // issue one product a cycle, accumulate it the cycle after
            if (mcnt_ff < 5'd24) begin
               prod_in = w_ff[mcnt_ff[1:0]] * coord;
               mv_in   = 1'b1;
               mcnt_in = mcnt_ff + 1'b1;
            end
            if (mv_ff) begin
               sum    = ((mcd_ff[1:0] == 2'd0) ? AB'(0) : acc_ff) + AB'(prod_ff);
               acc_in = sum;
               if (mcd_ff[1:0] == 2'd3) begin
                  rsum = sum + (AB'(1) <<< 16);
                  rq   = rsum[AB-1:17];
                  if (rq > (AB-17)'(2**(CB-1) - 1)) begin
                     held_in[mcd_ff[4:2]] = {1'b0, {(CB-1){1'b1}}};
                  end else if (rq < -(AB-17)'(2**(CB-1))) begin
                     held_in[mcd_ff[4:2]] = {1'b1, {(CB-1){1'b0}}};
                  end else begin
                     held_in[mcd_ff[4:2]] = rq[CB-1:0];
                  end
                  if (mcd_ff == 5'd23) begin
                     state_in = kspi_pkg::ST_DONE;
                  end
               end
            end
         end

         kspi_pkg::ST_DONE: begin
            // load the output register once it is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_co_in    = held_ff;
               rsp_seg_in   = seg_ff;
               rsp_fin_in   = fin_ff;
               state_in     = kspi_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = kspi_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kspi_pkg::ST_IDLE;
         elapsed_ff   <= '0;
         seg_ff       <= '0;
         len_ff       <= LB'(2);
         fin_ff       <= 1'b0;
         mv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < 6; c++) begin
            held_ff[c] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         elapsed_ff   <= elapsed_in;
         seg_ff       <= seg_in;
         len_ff       <= len_in;
         fin_ff       <= fin_in;
         mv_ff        <= mv_in;
         rsp_valid_ff <= rsp_valid_in;
         held_ff      <= held_in;
      end
      n_ff       <= n_in;
      pts_ff     <= pts_in;
      fcnt_ff    <= fcnt_in;
      u_ff       <= u_in;
      u2_ff      <= u2_in;
      u3_ff      <= u3_in;
      w_ff       <= w_in;
      mcnt_ff    <= mcnt_in;
      mcd_ff     <= mcd_in;
      prod_ff    <= prod_in;
      acc_ff     <= acc_in;
      rsp_co_ff  <= rsp_co_in;
      rsp_seg_ff <= rsp_seg_in;
      rsp_fin_ff <= rsp_fin_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cam_pos_x  = rsp_co_ff[0];
   assign rsp_cam_pos_y  = rsp_co_ff[1];
   assign rsp_cam_pos_z  = rsp_co_ff[2];
   assign rsp_cam_look_x = rsp_co_ff[3];
   assign rsp_cam_look_y = rsp_co_ff[4];
   assign rsp_cam_look_z = rsp_co_ff[5];
   assign rsp_segment    = rsp_seg_ff;
   assign rsp_finished   = rsp_fin_ff;

endmodule

// ===== hw/rtl/kspi_key_mem.sv =====
// ----------------------------------------------------------------------------
// kspi_key_mem
// keyframe table, one write port and one registered read port
// ----------------------------------------------------------------------------
module kspi_key_mem (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [kspi_pkg::KEY_AW-1:0] wr_addr,
   input  kspi_pkg::entry_type      wr_data,
   input  logic [kspi_pkg::KEY_AW-1:0] rd_addr,
   output kspi_pkg::entry_type      rd_data
);

   kspi_pkg::entry_type mem [kspi_pkg::MAX_KEYS];
   kspi_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/kspi_div.sv =====
// ----------------------------------------------------------------------------
// kspi_div
// restoring divider for the segment fraction, one quotient bit per cycle
// ----------------------------------------------------------------------------
module kspi_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [kspi_pkg::TIME_BITS-1:0] num,
   input  logic [kspi_pkg::TIME_BITS-1:0] den,
   output logic                          done,
   output logic [kspi_pkg::FRAC_BITS-1:0] quot
);

   localparam int CW = $clog2(kspi_pkg::FRAC_BITS + 1);

   logic [kspi_pkg::TIME_BITS-1:0] rem_ff, rem_in;
   logic [kspi_pkg::TIME_BITS-1:0] den_ff, den_in;
   logic [kspi_pkg::FRAC_BITS-1:0] quot_ff, quot_in;
   logic [CW-1:0]                  cnt_ff, cnt_in;
   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [kspi_pkg::TIME_BITS:0]   rem2;
   logic [kspi_pkg::TIME_BITS:0]   diff;

   // num < den, so the remainder stays below den and 2*rem fits
   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem2    = {rem_ff, 1'b0};
      diff    = rem2 - {1'b0, den_ff};
      if (start) begin
         rem_in  = num;
         den_in  = den;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem2 >= {1'b0, den_ff}) begin
            rem_in  = diff[kspi_pkg::TIME_BITS-1:0];
            quot_in = {quot_ff[kspi_pkg::FRAC_BITS-2:0], 1'b1};
         end else begin
            rem_in  = rem2[kspi_pkg::TIME_BITS-1:0];
            quot_in = {quot_ff[kspi_pkg::FRAC_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(kspi_pkg::FRAC_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
      cnt_ff  <= cnt_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

// ===== bench/tb_keyframe_spline_path_interpolator_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_keyframe_spline_path_interpolator_core
// fills the keyframe table, runs directed and random write and tick traffic
// over several path lengths, predicts every camera sample and compares it
// ----------------------------------------------------------------------------
module tb_keyframe_spline_path_interpolator_core;

   localparam longint TIME_TOP   = (64'd1 << kspi_pkg::TIME_BITS) - 1;
   localparam longint UNIT       = 65536;
   localparam int     CYCLE_LIMIT = 1500000;
   localparam int     SETTLE      = 80;

   typedef struct packed {
      logic        op;
      logic [5:0]  idx;
      logic signed [15:0] px, py, pz, lx, ly, lz;
      logic [23:0] ktime;
      logic [15:0] delta;
   } key_req_type;

   typedef struct packed {
      logic signed [15:0] px, py, pz, lx, ly, lz;
      logic [6:0] seg;
      logic       fin;
   } cam_sample_type;

   // camera path predictor and queue of camera samples still owed by the block
   class camera_path_scoreboard;
      longint kpos[3][kspi_pkg::MAX_KEYS];
      longint klook[3][kspi_pkg::MAX_KEYS];
      longint ktime[kspi_pkg::MAX_KEYS];
      longint elapsed;
      int     seg;
      longint hpos[3];
      longint hlook[3];
      int     plen;
      cam_sample_type owed[$];
      int     mismatches;
      int     samples_seen;
      int     finished_seen;

      function void clear();
         elapsed = 0;
         seg = 0;
         plen = 2;
         mismatches = 0;
         samples_seen = 0;
         finished_seen = 0;
         for (int i = 0; i < 3; i++) begin
            hpos[i] = 0;
            hlook[i] = 0;
         end
         for (int k = 0; k < kspi_pkg::MAX_KEYS; k++) begin
            ktime[k] = 0;
            for (int i = 0; i < 3; i++) begin
               kpos[i][k] = 0;
               klook[i][k] = 0;
            end
         end
      endfunction

      function longint rnd(longint v, int k);
         return (v + (longint'(1) << (k - 1))) >>> k;
      endfunction

      function longint mix(longint w[4], longint a, longint b, longint c, longint d);
         longint r;
         r = rnd(w[0] * a + w[1] * b + w[2] * c + w[3] * d, 17);
         if (r < -32768) r = -32768;
         if (r > 32767) r = 32767;
         return r;
      endfunction

      function void push_sample(logic fin);
         cam_sample_type s;
         s.px = hpos[0][15:0];
         s.py = hpos[1][15:0];
         s.pz = hpos[2][15:0];
         s.lx = hlook[0][15:0];
         s.ly = hlook[1][15:0];
         s.lz = hlook[2][15:0];
         s.seg = seg[6:0];
         s.fin = fin;
         owed = {owed, s};
      endfunction

      function void note_transfer(key_req_type r);
         int n, cur, nxt, bef, aft;
         longint t0, t1, u, u2, u3, f[4], w[4];
         if (r.op == kspi_pkg::OP_WRITE) begin
            kpos[0][r.idx] = r.px;
            kpos[1][r.idx] = r.py;
            kpos[2][r.idx] = r.pz;
            klook[0][r.idx] = r.lx;
            klook[1][r.idx] = r.ly;
            klook[2][r.idx] = r.lz;
            ktime[r.idx] = r.ktime;
            return;
         end
         n = plen;
         if (n < 2) n = 2;
         if (n > kspi_pkg::MAX_KEYS) n = kspi_pkg::MAX_KEYS;
         elapsed += r.delta;
         if (elapsed > TIME_TOP) elapsed = TIME_TOP;
         if (seg + 2 < n) begin
            if (elapsed > ktime[seg + 1]) seg++;
            cur = seg;
            nxt = seg + 1;
            bef = (seg == 0) ? cur : seg - 1;
            aft = (seg + 2 == n) ? nxt : seg + 2;
         end else if (seg + 2 == n) begin
            cur = seg;
            nxt = seg + 1;
            if (elapsed > ktime[nxt]) begin
               // last key passed: park on it
               seg = nxt;
               for (int i = 0; i < 3; i++) begin
                  hpos[i] = kpos[i][nxt];
                  hlook[i] = klook[i][nxt];
               end
               push_sample(1'b1);
               return;
            end
            bef = (seg == 0) ? cur : seg - 1;
            aft = nxt;
         end else begin
            push_sample(1'b1);
            return;
         end
         t0 = ktime[cur];
         t1 = ktime[nxt];
         if (t1 <= t0) u = UNIT;
         else if (elapsed <= t0) u = 0;
         else if (elapsed - t0 >= t1 - t0) u = UNIT;
         else u = ((elapsed - t0) * UNIT) / (t1 - t0);
         u2 = u * u;
         u3 = u2 * u;
         f[0] = -u3 + 2 * u2 * UNIT - u * (longint'(1) << 32);
         f[1] = 3 * u3 - 5 * u2 * UNIT + 2 * (longint'(1) << 48);
         f[2] = -3 * u3 + 4 * u2 * UNIT + u * (longint'(1) << 32);
         f[3] = u3 - u2 * UNIT;
         for (int i = 0; i < 4; i++) w[i] = rnd(f[i], 32);
         for (int i = 0; i < 3; i++) begin
            hpos[i] = mix(w, kpos[i][bef], kpos[i][cur], kpos[i][nxt], kpos[i][aft]);
            hlook[i] = mix(w, klook[i][bef], klook[i][cur], klook[i][nxt], klook[i][aft]);
         end
         push_sample(1'b0);
      endfunction

      function void check_sample(cam_sample_type got);
         cam_sample_type exp_s;
         samples_seen++;
         if (got.fin) finished_seen++;
         if (owed.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("[%0t] unexpected camera sample %p", $time, got);
            return;
         end
         exp_s = owed.pop_front();
         if (got !== exp_s) begin
            mismatches++;
            if (mismatches <= 10)
               $display("[%0t] sample mismatch\n  expected %p\n  actual   %p",
                        $time, exp_s, got);
         end
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   key_req_type        req;
   logic               rsp_valid;
   logic               rsp_stall;
   cam_sample_type     rsp;
   logic               csr_wr_en;
   logic [6:0]         csr_wr_data;

   camera_path_scoreboard sb;
   int cycles;
   int tx_idle_pct;
   int rx_idle_pct;
   int ticks_sent;
   int writes_sent;

   keyframe_spline_path_interpolator_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req.op),
      .req_key_index  (req.idx),
      .req_key_pos_x  (req.px),
      .req_key_pos_y  (req.py),
      .req_key_pos_z  (req.pz),
      .req_key_look_x (req.lx),
      .req_key_look_y (req.ly),
      .req_key_look_z (req.lz),
      .req_key_time   (req.ktime),
      .req_delta_t    (req.delta),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_cam_pos_x  (rsp.px),
      .rsp_cam_pos_y  (rsp.py),
      .rsp_cam_pos_z  (rsp.pz),
      .rsp_cam_look_x (rsp.lx),
      .rsp_cam_look_y (rsp.ly),
      .rsp_cam_look_z (rsp.lz),
      .rsp_segment    (rsp.seg),
      .rsp_finished   (rsp.fin),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // watchdog on total cycles
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d samples still owed", cycles,
                  sb.owed.size());
         $display("** keyframe_spline_path_interpolator_core: FAILED **");
         $finish;
      end
   end

   // receiver: random stall, check each accepted sample against the oldest one owed
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_sample(rsp);
      rsp_stall <= ($urandom_range(99) < rx_idle_pct);
   end

   // drive one request and hold it until the transfer happens
   task automatic send(key_req_type r);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_transfer(r);
      if (r.op == kspi_pkg::OP_TICK) ticks_sent++;
      else writes_sent++;
   endtask

   function automatic logic signed [15:0] pick_coord();
      case ($urandom_range(7))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic put_key(int idx, longint t);
      key_req_type r;
      r = '0;
      r.op = kspi_pkg::OP_WRITE;
      r.idx = idx[5:0];
      r.px = pick_coord();
      r.py = pick_coord();
      r.pz = pick_coord();
      r.lx = pick_coord();
      r.ly = pick_coord();
      r.lz = pick_coord();
      if (t > TIME_TOP) t = TIME_TOP;
      r.ktime = t[23:0];
      r.delta = 16'($urandom);   // ignored by writes, toggles anyway
      send(r);
   endtask

   task automatic tick(int d);
      key_req_type r;
      r = '0;
      r.op = kspi_pkg::OP_TICK;
      // key fields are ignored by ticks, toggle them anyway
      r.idx = 6'($urandom);
      r.px = pick_coord();
      r.py = pick_coord();
      r.pz = pick_coord();
      r.lx = pick_coord();
      r.ly = pick_coord();
      r.lz = pick_coord();
      r.ktime = 24'($urandom);
      r.delta = d[15:0];
      send(r);
   endtask

   // let the block drain, then write the path length while it is idle
   task automatic set_length(int v);
      req_valid <= 1'b0;
      while (sb.owed.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v[6:0];
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.plen = v;
   endtask

   task automatic random_traffic(int count, bit push_hard);
      int r, idx, d;
      longint base;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(99);
         if (r < 25) begin
            // well-formed: keys just ahead of the current segment, later times
            idx = sb.seg + 1 + $urandom_range(0, 3);
            if (idx > kspi_pkg::MAX_KEYS - 1) idx = kspi_pkg::MAX_KEYS - 1;
            base = (sb.ktime[idx - 1] > sb.elapsed) ? sb.ktime[idx - 1] : sb.elapsed;
            put_key(idx, base + $urandom_range(1, 60000));
         end else if (r < 31) begin
            // noise: any slot, repeated or backward time, or a start not yet reached
            case ($urandom_range(2))
               0: put_key($urandom_range(0, kspi_pkg::MAX_KEYS - 1),
                          $urandom_range(0, 24'hFFFFFF));
               1: begin
                  idx = $urandom_range(1, kspi_pkg::MAX_KEYS - 1);
                  put_key(idx, sb.ktime[idx - 1] - $urandom_range(0, 1));
               end
               default: put_key(sb.seg < kspi_pkg::MAX_KEYS ? sb.seg : 0,
                                sb.elapsed + $urandom_range(0, 3000));
            endcase
         end else begin
            case ($urandom_range(9))
               0: d = 0;
               1: d = 16'hFFFF;
               default: d = push_hard ? $urandom_range(0, 65535) : $urandom_range(0, 20000);
            endcase
            tick(d);
         end
      end
   endtask

   initial begin
      int lengths[6];
      sb = new();
      sb.clear();
      cycles = 0;
      ticks_sent = 0;
      writes_sent = 0;
      tx_idle_pct = 25;
      rx_idle_pct = 64;
      reset = 1'b1;
      req_valid = 1'b0;
      req = '0;
      rsp_stall = 1'b0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // whole table is written first so no tick ever reads an empty slot
      for (int k = 0; k < kspi_pkg::MAX_KEYS; k++) put_key(k, 1000 + k * 30000);

      // directed: two-point path at its reset length, extreme keys and deltas
      tick(0);            // elapsed still before the first key time
      tick(0);
      tick(15000);        // mid segment, start key reused as its own neighbour
      tick(16'hFFFF);     // passes the last key, finished
      tick(0);            // held
      set_length(4);
      tick(1);            // advances a segment, interpolated
      put_key(1, 70000);
      put_key(2, 70000);  // zero duration segment
      set_length(64);
      tick(1);
      put_key(3, 60000);  // key time going backward
      tick(1);
      put_key(4, 200000);
      put_key(5, 300000);
      tick(0);
      tick(40000);
      tick(40000);
      put_key(63, 16'hFFFF);
      tick(16'hFFFF);

      lengths = '{37, 2, 127, 0, 64, 100};
      for (int p = 0; p < 6; p++) begin
         case (p % 3)
            0: begin tx_idle_pct = 25; rx_idle_pct = 64; end
            1: begin tx_idle_pct = 64; rx_idle_pct = 25; end
            default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
         endcase
         set_length(lengths[p]);
         random_traffic(p == 1 || p == 3 ? 100 : 240, p == 5);
      end

      req_valid <= 1'b0;
      while (sb.owed.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);

      $display("covered %0d ticks and %0d key writes over six path lengths,", ticks_sent,
               writes_sent);
      $display("%0d camera samples checked, %0d of them finished, elapsed %0d",
               sb.samples_seen, sb.finished_seen, sb.elapsed);
      if (sb.mismatches == 0 && sb.owed.size() == 0) begin
         $display("** keyframe_spline_path_interpolator_core: PASSED **");
      end else begin
         $display("%0d mismatches, %0d samples never delivered", sb.mismatches,
                  sb.owed.size());
         $display("** keyframe_spline_path_interpolator_core: FAILED **");
      end
      $finish;
   end

endmodule
